// ----- sv/gso_pkg.sv -----
`timescale 1ns / 1ps
package gso_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int RSQRT_STEPS = 3;
  localparam int IN_W        = 24;
  localparam int OUT_W       = 18;
  localparam int ROW_W       = 30;
  localparam int U_W         = FRAC_BITS + 2;
  localparam int DOT_W       = 32;
  localparam int SUM_W       = 2 * ROW_W + 2;
  localparam int NORM_FIXED  = 7;
  localparam int PROJ_LAT    = 4;

  localparam logic [U_W-1:0] ONE = {2'b01, {FRAC_BITS{1'b0}}};

  typedef logic [2:0][ROW_W-1:0] row_t;
  typedef logic [2:0][U_W-1:0]   urow_t;

  function automatic logic [9:0] seed(input logic [3:0] idx);
    logic [9:0] s;
    case (idx)
      4'd0:    s = 10'd965;
      4'd1:    s = 10'd873;
      4'd2:    s = 10'd803;
      4'd3:    s = 10'd748;
      4'd4:    s = 10'd702;
      4'd5:    s = 10'd664;
      4'd6:    s = 10'd632;
      4'd7:    s = 10'd604;
      4'd8:    s = 10'd579;
      4'd9:    s = 10'd557;
      4'd10:   s = 10'd538;
      default: s = 10'd520;
    endcase
    return s;
  endfunction

  function automatic logic [63:0] ushr_rnd(input logic [63:0] v, input logic [6:0] r);
    logic [63:0] h;
    h = 64'd1 << (r - 7'd1);
    if (r == 7'd0) begin
      return v;
    end
    if (r >= 7'd63) begin
      return 64'd0;
    end
    return (v + h) >> r;
  endfunction

  function automatic logic signed [63:0] sshr_rnd(input logic signed [63:0] v,
                                                 input logic [6:0] r);
    logic [63:0] m;
    m = v[63] ? (~v + 64'd1) : v;
    m = ushr_rnd(m, r);
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ----- sv/gso_proj.sv -----
`timescale 1ns / 1ps
module gso_proj (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  gso_pkg::row_t       a_i,
  input  gso_pkg::urow_t      u_i,
  output logic                vld_o,
  output gso_pkg::row_t       a_o
);

  localparam int RW = gso_pkg::ROW_W;
  localparam int PW = gso_pkg::ROW_W + gso_pkg::U_W;
  localparam int QW = gso_pkg::U_W + gso_pkg::DOT_W;
  localparam logic [6:0] FB = 7'(gso_pkg::FRAC_BITS);

  logic [3:0]                      v_q;
  logic signed [PW-1:0]            p1_q [3];
  gso_pkg::row_t                   a1_q, a2_q, a3_q, a4_q;
  gso_pkg::urow_t                  u1_q, u2_q;
  logic signed [gso_pkg::DOT_W-1:0] dot_q, dot_d;
  logic signed [QW-1:0]            p3_q [3];
  logic signed [PW+1:0]            sum;

  always_comb begin
    sum   = (PW+2)'(p1_q[0]) + (PW+2)'(p1_q[1]) + (PW+2)'(p1_q[2]);
    dot_d = gso_pkg::DOT_W'(gso_pkg::sshr_rnd(64'(sum), FB));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        p1_q[i] <= $signed(a_i[i]) * $signed(u_i[i]);
        p3_q[i] <= $signed(u2_q[i]) * dot_q;
        a4_q[i] <= RW'(64'($signed(a3_q[i])) - gso_pkg::sshr_rnd(64'(p3_q[i]), FB));
      end
      a1_q  <= a_i;
      u1_q  <= u_i;
      a2_q  <= a1_q;
      u2_q  <= u1_q;
      dot_q <= dot_d;
      a3_q  <= a2_q;
    end
  end

  assign vld_o = v_q[3];
  assign a_o   = a4_q;

endmodule

// ----- sv/gso_norm.sv -----
`timescale 1ns / 1ps
module gso_norm #(
  parameter int RSQRT_STEPS = gso_pkg::RSQRT_STEPS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  gso_pkg::row_t       a_i,
  output logic                vld_o,
  output gso_pkg::urow_t      o_o,
  output logic                deg_o
);

  localparam int RW = gso_pkg::ROW_W;
  localparam int UW = gso_pkg::U_W;
  localparam int SW = gso_pkg::SUM_W;
  localparam int NS = 3 * RSQRT_STEPS;

  typedef struct packed {
    logic [2:0][RW-1:0] mag;
    logic [2:0]         sgn;
    logic               zero;
    logic [31:0]        m;
    logic [6:0]         r;
  } nctx_t;

  logic [3:0]          nv_q;
  logic [2:0][RW-1:0]  mag1_q, mag2_q, mag3_q, mag4_q, mag_d;
  logic [2:0]          sgn1_q, sgn2_q, sgn3_q, sgn4_q;
  logic [2*RW-1:0]     sq1_q [3];
  logic [SW-1:0]       s2_q, s3_q, s4_q;
  logic [2:0]          bi3_q, bi_d, bb;
  logic [7:0]          by3_q;
  logic                zero3_q, zero4_q;
  logic signed [7:0]   d4_q, d_d;
  logic [63:0]         sp3, sp4, m64;
  logic signed [8:0]   rr;
  logic [3:0]          ix;
  nctx_t               c0_d;

  logic [NS:0]         sv_q;
  nctx_t               sc_q [NS+1];
  logic [31:0]         sy_q [NS+1];
  logic [31:0]         y0_d;
  logic [31:0]         q_q [RSQRT_STEPS];
  logic [31:0]         h_q [RSQRT_STEPS];

  logic [1:0]          fv_q;
  logic [RW+31:0]      pv_q [3];
  logic [2:0]          fsgn_q;
  logic                fzero_q, deg_q;
  logic [6:0]          fr_q;
  gso_pkg::urow_t      o_q, o_d;
  logic [63:0]         vv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = a_i[i][RW-1] ? RW'(-$signed(a_i[i])) : a_i[i];
    end
    sp3  = 64'(s2_q);
    bi_d = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (|sp3[8*i +: 8]) begin
        bi_d = 3'(i);
      end
    end
    bb = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (by3_q[i]) begin
        bb = 3'(i);
      end
    end
    d_d = $signed(8'(bb[0] ? 31 : 30)) - $signed({2'b00, bi3_q, bb});
    sp4 = 64'(s4_q);
    m64 = d4_q[7] ? (sp4 >> 6'(-d4_q)) : (sp4 << d4_q[5:0]);
    rr  = 9'(45 - gso_pkg::FRAC_BITS) - 9'(d4_q / 8'sd2);
    ix  = m64[31:28] - 4'd4;
    if (ix > 4'd11) begin
      ix = 4'd11;
    end
    y0_d      = 32'(gso_pkg::seed(ix)) << 20;
    c0_d.mag  = mag4_q;
    c0_d.sgn  = sgn4_q;
    c0_d.zero = zero4_q;
    c0_d.m    = m64[31:0];
    c0_d.r    = rr[8] ? 7'd0 : rr[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= '0;
      sv_q <= '0;
      fv_q <= '0;
    end else if (en_i) begin
      nv_q <= {nv_q[2:0], vld_i};
      sv_q <= {sv_q[NS-1:0], nv_q[3]};
      fv_q <= {fv_q[0], sv_q[NS]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq1_q[i] <= mag_d[i] * mag_d[i];
        sgn1_q[i] <= a_i[i][RW-1];
      end
      mag1_q  <= mag_d;
      s2_q    <= SW'(sq1_q[0]) + SW'(sq1_q[1]) + SW'(sq1_q[2]);
      mag2_q  <= mag1_q;
      sgn2_q  <= sgn1_q;
      bi3_q   <= bi_d;
      by3_q   <= sp3[8*bi_d +: 8];
      zero3_q <= ~|s2_q;
      s3_q    <= s2_q;
      mag3_q  <= mag2_q;
      sgn3_q  <= sgn2_q;
      d4_q    <= d_d;
      s4_q    <= s3_q;
      zero4_q <= zero3_q;
      mag4_q  <= mag3_q;
      sgn4_q  <= sgn3_q;
      sc_q[0] <= c0_d;
      sy_q[0] <= y0_d;
      for (int j = 0; j < NS; j++) begin
        sc_q[j+1] <= sc_q[j];
      end
    end
  end

  for (genvar k = 0; k < RSQRT_STEPS; k++) begin : g_step
    logic [63:0] t;
    assign t = (64'(sc_q[3*k+1].m) * 64'(q_q[k])) >> 30;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k]       <= 32'((64'(sy_q[3*k]) * 64'(sy_q[3*k])) >> 30);
        sy_q[3*k+1]  <= sy_q[3*k];
        h_q[k]       <= (t > (64'd3 << 30)) ? 32'd0 : 32'((64'd3 << 30) - t);
        sy_q[3*k+2]  <= sy_q[3*k+1];
        sy_q[3*k+3]  <= 32'((64'(sy_q[3*k+2]) * 64'(h_q[k])) >> 31);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vv[i] = gso_pkg::ushr_rnd(64'(pv_q[i]), fr_q);
      if (vv[i] > 64'(gso_pkg::ONE)) begin
        vv[i] = 64'(gso_pkg::ONE);
      end
      o_d[i] = fsgn_q[i] ? UW'(-vv[i]) : UW'(vv[i]);
    end
    if (fzero_q) begin
      o_d[0] = gso_pkg::ONE;
      o_d[1] = '0;
      o_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pv_q[i] <= (RW+32)'(sc_q[NS].mag[i]) * (RW+32)'(sy_q[NS]);
      end
      fsgn_q  <= sc_q[NS].sgn;
      fzero_q <= sc_q[NS].zero;
      fr_q    <= sc_q[NS].r;
      o_q     <= o_d;
      deg_q   <= fzero_q;
    end
  end

  assign vld_o = fv_q[1];
  assign o_o   = o_q;
  assign deg_o = deg_q;

endmodule

// ----- sv/gram_schmidt_orthonormalize_3x3.sv -----
`timescale 1ns / 1ps
// Orthonormalizes the rows of a 3x3 Q8.16 matrix by modified Gram-Schmidt and returns
// Q1.16 rows plus a mask of rows that had zero length and became (1,0,0). The block is a
// fixed-depth pipeline that takes one matrix every cycle while input ready is high; its
// depth is three normalization pipelines of 7+3*RSQRT_STEPS stages each (one multiply
// per stage in the reciprocal square root) and two 4-stage projection pipelines in
// series, followed by the output buffer.
// A two-entry output buffer holds results; input ready drops only when it holds two.
module gram_schmidt_orthonormalize_3x3 #(
  parameter int RSQRT_STEPS = gso_pkg::RSQRT_STEPS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [gso_pkg::IN_W-1:0]   in_r0c0_i,
  input  logic signed [gso_pkg::IN_W-1:0]   in_r0c1_i,
  input  logic signed [gso_pkg::IN_W-1:0]   in_r0c2_i,
  input  logic signed [gso_pkg::IN_W-1:0]   in_r1c0_i,
  input  logic signed [gso_pkg::IN_W-1:0]   in_r1c1_i,
  input  logic signed [gso_pkg::IN_W-1:0]   in_r1c2_i,
  input  logic signed [gso_pkg::IN_W-1:0]   in_r2c0_i,
  input  logic signed [gso_pkg::IN_W-1:0]   in_r2c1_i,
  input  logic signed [gso_pkg::IN_W-1:0]   in_r2c2_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [gso_pkg::OUT_W-1:0]  out_r0c0_o,
  output logic signed [gso_pkg::OUT_W-1:0]  out_r0c1_o,
  output logic signed [gso_pkg::OUT_W-1:0]  out_r0c2_o,
  output logic signed [gso_pkg::OUT_W-1:0]  out_r1c0_o,
  output logic signed [gso_pkg::OUT_W-1:0]  out_r1c1_o,
  output logic signed [gso_pkg::OUT_W-1:0]  out_r1c2_o,
  output logic signed [gso_pkg::OUT_W-1:0]  out_r2c0_o,
  output logic signed [gso_pkg::OUT_W-1:0]  out_r2c1_o,
  output logic signed [gso_pkg::OUT_W-1:0]  out_r2c2_o,
  output logic [2:0]                        degenerate_rows_o
);

  localparam int RW  = gso_pkg::ROW_W;
  localparam int OW  = gso_pkg::OUT_W;
  localparam int LN  = gso_pkg::NORM_FIXED + 3 * RSQRT_STEPS;
  localparam int LP  = gso_pkg::PROJ_LAT;
  localparam int LU0 = 2 * LN + 2 * LP;
  localparam int LU1 = LN + LP;

  typedef struct packed {
    gso_pkg::urow_t u0;
    gso_pkg::urow_t u1;
    gso_pkg::urow_t u2;
    logic [2:0]     deg;
  } res_t;

  logic           en, push, pop;
  gso_pkg::row_t  r0, r1, r2;
  gso_pkg::row_t  p0_a, p1_a, p2_a;
  gso_pkg::urow_t u0, u1, u2;
  logic           n0_v, n1_v, n2_v, p0_v, p1_v, p2_v;
  logic           g0, g1, g2;

  gso_pkg::row_t  dr1_q [LN];
  gso_pkg::row_t  dr2_q [LN];
  gso_pkg::row_t  dp1_q [LN];
  logic [LN-1:0]  dpv_q;
  logic [gso_pkg::U_W*3:0] du0_q [LU0];
  logic [gso_pkg::U_W*3:0] du1_q [LU1];

  res_t           buf_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  res_t           res_d;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;

  assign r0[0] = RW'(in_r0c0_i);
  assign r0[1] = RW'(in_r0c1_i);
  assign r0[2] = RW'(in_r0c2_i);
  assign r1[0] = RW'(in_r1c0_i);
  assign r1[1] = RW'(in_r1c1_i);
  assign r1[2] = RW'(in_r1c2_i);
  assign r2[0] = RW'(in_r2c0_i);
  assign r2[1] = RW'(in_r2c1_i);
  assign r2[2] = RW'(in_r2c2_i);

  gso_norm #(.RSQRT_STEPS(RSQRT_STEPS)) u_norm0 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i), .a_i(r0),
    .vld_o(n0_v), .o_o(u0), .deg_o(g0)
  );

  gso_proj u_proj0 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(n0_v), .a_i(dr1_q[LN-1]), .u_i(u0),
    .vld_o(p0_v), .a_o(p0_a)
  );

  gso_proj u_proj1 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(n0_v), .a_i(dr2_q[LN-1]), .u_i(u0),
    .vld_o(p1_v), .a_o(p1_a)
  );

  gso_norm #(.RSQRT_STEPS(RSQRT_STEPS)) u_norm1 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(p0_v), .a_i(p0_a),
    .vld_o(n1_v), .o_o(u1), .deg_o(g1)
  );

  gso_proj u_proj2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(n1_v && dpv_q[LN-1]), .a_i(dp1_q[LN-1]), .u_i(u1),
    .vld_o(p2_v), .a_o(p2_a)
  );

  gso_norm #(.RSQRT_STEPS(RSQRT_STEPS)) u_norm2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(p2_v), .a_i(p2_a),
    .vld_o(n2_v), .o_o(u2), .deg_o(g2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpv_q <= '0;
    end else if (en) begin
      dpv_q <= {dpv_q[LN-2:0], p1_v};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dr1_q[0] <= r1;
      dr2_q[0] <= r2;
      dp1_q[0] <= p1_a;
      du0_q[0] <= {u0, g0};
      du1_q[0] <= {u1, g1};
      for (int i = 1; i < LN; i++) begin
        dr1_q[i] <= dr1_q[i-1];
        dr2_q[i] <= dr2_q[i-1];
        dp1_q[i] <= dp1_q[i-1];
      end
      for (int i = 1; i < LU0; i++) begin
        du0_q[i] <= du0_q[i-1];
      end
      for (int i = 1; i < LU1; i++) begin
        du1_q[i] <= du1_q[i-1];
      end
    end
  end

  assign push = en && n2_v;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    res_d.u0  = du0_q[LU0-1][gso_pkg::U_W*3:1];
    res_d.u1  = du1_q[LU1-1][gso_pkg::U_W*3:1];
    res_d.u2  = u2;
    res_d.deg = {g2, du1_q[LU1-1][0], du0_q[LU0-1][0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= res_d;
    end
  end

  assign out_valid_o       = (cnt_q != 2'd0);
  assign out_r0c0_o        = OW'(buf_q[rd_q].u0[0]);
  assign out_r0c1_o        = OW'(buf_q[rd_q].u0[1]);
  assign out_r0c2_o        = OW'(buf_q[rd_q].u0[2]);
  assign out_r1c0_o        = OW'(buf_q[rd_q].u1[0]);
  assign out_r1c1_o        = OW'(buf_q[rd_q].u1[1]);
  assign out_r1c2_o        = OW'(buf_q[rd_q].u1[2]);
  assign out_r2c0_o        = OW'(buf_q[rd_q].u2[0]);
  assign out_r2c1_o        = OW'(buf_q[rd_q].u2[1]);
  assign out_r2c2_o        = OW'(buf_q[rd_q].u2[2]);
  assign degenerate_rows_o = buf_q[rd_q].deg;

endmodule

// ----- sv/gso_chk.sv -----
`timescale 1ns / 1ps
module gso_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [gso_pkg::OUT_W-1:0]  out_r0c0_o,
  input logic signed [gso_pkg::OUT_W-1:0]  out_r0c1_o,
  input logic signed [gso_pkg::OUT_W-1:0]  out_r0c2_o,
  input logic signed [gso_pkg::OUT_W-1:0]  out_r2c2_o,
  input logic [2:0]                        degenerate_rows_o
);

  localparam logic signed [gso_pkg::OUT_W-1:0] ONE_S = $signed(gso_pkg::ONE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_r0c0_o)
      && $stable(degenerate_rows_o))
    else $error("result changed while stalled");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_deg_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_rows_o[0] |->
      out_r0c0_o == ONE_S && out_r0c1_o == '0 && out_r0c2_o == '0)
    else $error("zero-length row 0 not mapped to unit x");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_r2c2_o <= ONE_S && out_r2c2_o >= -ONE_S)
    else $error("component beyond one unit");

endmodule

bind gram_schmidt_orthonormalize_3x3 gso_chk u_gso_chk (.*);
